>>> hdl/tccb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tccb_pkg;

   // Fixed field widths of the request and result transactions.
   localparam int unsigned REQ_TYPE_W    = 2;
   localparam int unsigned CHAR_W        = 8;
   localparam int unsigned LINE_W        = 5;
   localparam int unsigned POS_W         = 7;
   localparam int unsigned REQ_TDATA_W   = 24;
   localparam int unsigned RSP_TDATA_W   = 24;

   localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_PUT   = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_READ  = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_POST
   } state_type;

   typedef struct packed {
      logic              scrolled;
      logic [POS_W-1:0]  cursor_pos;
      logic [LINE_W-1:0] cursor_line;
      logic [CHAR_W-1:0] cell_char;
   } result_type;

endpackage

`default_nettype wire

>>> hdl/tccb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tccb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/tccb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tccb_ctrl #(
   parameter int unsigned ROWS    = 25,
   parameter int unsigned COLUMNS = 80,
   parameter int unsigned RW      = $clog2(ROWS),
   parameter int unsigned CW      = $clog2(COLUMNS)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [tccb_pkg::REQ_TYPE_W-1:0]     req_type,
   input  wire logic [tccb_pkg::CHAR_W-1:0]         char_code,
   input  wire logic [tccb_pkg::LINE_W-1:0]         read_row,
   input  wire logic [tccb_pkg::POS_W-1:0]          read_col,
   output logic                                     ram_wr_en,
   output logic      [RW+CW-1:0]                    ram_wr_addr,
   output logic      [tccb_pkg::CHAR_W-1:0]         ram_wr_data,
   output logic                                     ram_rd_en,
   output logic      [RW+CW-1:0]                    ram_rd_addr,
   input  wire logic [tccb_pkg::CHAR_W-1:0]         ram_rd_data,
   output logic                                     res_valid,
   output tccb_pkg::result_type                     res_data,
   input  wire logic                                out_free
);

   import tccb_pkg::*;

   localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
   localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

   // Logical row to physical row: the screen is a ring of rows starting at top_ff.
   function automatic logic [RW-1:0] ring_add(input logic [RW-1:0] a, input logic [RW-1:0] b);
      logic [RW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (RW+1)'(ROWS)) begin
         sum = sum - (RW+1)'(ROWS);
      end
      return sum[RW-1:0];
   endfunction

   state_type   state_ff, state_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] top_ff, top_in;
   logic [RW-1:0] sw_row_ff, sw_row_in;
   logic [CW-1:0] sw_col_ff, sw_col_in;
   logic [RW-1:0] sw_end_ff, sw_end_in;
   logic          sw_rsp_ff, sw_rsp_in;
   logic          rd_pend_ff, rd_pend_in;
   result_type    res_ff, res_in;

   logic [RW-1:0] phys_row;
   logic          take_newline;
   logic          read_hit;

   assign phys_row = ring_add(row_ff, top_ff);
   assign read_hit = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SWEEP;
         row_ff     <= '0;
         col_ff     <= '0;
         top_ff     <= '0;
         sw_row_ff  <= '0;
         sw_col_ff  <= '0;
         sw_end_ff  <= ROW_LAST;
         sw_rsp_ff  <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         top_ff     <= top_in;
         sw_row_ff  <= sw_row_in;
         sw_col_ff  <= sw_col_in;
         sw_end_ff  <= sw_end_in;
         sw_rsp_ff  <= sw_rsp_in;
         rd_pend_ff <= rd_pend_in;
      end
      res_ff <= res_in;
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      top_in       = top_ff;
      sw_row_in    = sw_row_ff;
      sw_col_in    = sw_col_ff;
      sw_end_in    = sw_end_ff;
      sw_rsp_in    = sw_rsp_ff;
      rd_pend_in   = rd_pend_ff;
      res_in       = res_ff;
      take_newline = 1'b0;
      req_ready    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = {phys_row, col_ff};
      ram_wr_data  = char_code;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = {RW'(read_row), CW'(read_col)};
      res_valid    = 1'b0;
      res_data     = res_ff;
      res_data.cell_char = rd_pend_ff ? ram_rd_data : '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rd_pend_in = 1'b0;
               res_in.scrolled = 1'b0;
               state_in = ST_POST;
               case (req_type)
                  REQ_PUT: begin
                     if (char_code == CODE_NEWLINE) begin
                        take_newline = 1'b1;
                     end else if (char_code == CODE_BACKSPACE) begin
                        if (col_ff != '0) begin
                           col_in      = col_ff - 1'b1;
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = {phys_row, col_ff - 1'b1};
                           ram_wr_data = '0;
                        end
                     end else begin
                        ram_wr_en = 1'b1;
                        if (col_ff == COL_LAST) begin
                           take_newline = 1'b1;
                        end else begin
                           col_in = col_ff + 1'b1;
                        end
                     end
                     if (take_newline) begin
                        col_in = '0;
                        if (row_ff != ROW_LAST) begin
                           row_in = row_ff + 1'b1;
                        end else begin
                           // The old top row becomes the new bottom row and is wiped.
                           res_in.scrolled = 1'b1;
                           top_in    = (top_ff == ROW_LAST) ? '0 : top_ff + 1'b1;
                           sw_row_in = top_ff;
                           sw_end_in = top_ff;
                           sw_col_in = '0;
                           sw_rsp_in = 1'b1;
                           state_in  = ST_SWEEP;
                        end
                     end
                  end
                  REQ_CLEAR: begin
                     row_in    = '0;
                     col_in    = '0;
                     top_in    = '0;
                     sw_row_in = '0;
                     sw_end_in = ROW_LAST;
                     sw_col_in = '0;
                     sw_rsp_in = 1'b1;
                     state_in  = ST_SWEEP;
                  end
                  REQ_READ: begin
                     ram_rd_en   = read_hit;
                     ram_rd_addr = {ring_add(RW'(read_row), top_ff), CW'(read_col)};
                     rd_pend_in  = read_hit;
                  end
                  default: begin
                  end
               endcase
               res_in.cursor_line = LINE_W'(row_in);
               res_in.cursor_pos  = POS_W'(col_in);
            end
         end
         ST_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = {sw_row_ff, sw_col_ff};
            ram_wr_data = '0;
            if (sw_col_ff == COL_LAST) begin
               sw_col_in = '0;
               if (sw_row_ff == sw_end_ff) begin
                  state_in = sw_rsp_ff ? ST_POST : ST_IDLE;
               end else begin
                  sw_row_in = sw_row_ff + 1'b1;
               end
            end else begin
               sw_col_in = sw_col_ff + 1'b1;
            end
         end
         ST_POST: begin
            res_valid = 1'b1;
            if (out_free) begin
               rd_pend_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/text_console_cell_buffer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A put, read or unused request is accepted in the idle state, its result is set up in the
// post state and then registered at the output; a scroll first wipes the new bottom row and a
// clear first wipes the whole screen. No new request is taken until the result of the last
// one has left the post state, which waits while the output stalls; the row wipe of a scroll
// and the full wipe of a clear go one cell per cycle through the single write port of the cell
// memory. Reset is synchronous and active high; after it a clearing pass keeps req_tready low.

module text_console_cell_buffer_top #(
   parameter int unsigned ROWS    = 25,
   parameter int unsigned COLUMNS = 80
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // tuser: req_type[1:0]
   input  wire logic [tccb_pkg::REQ_TYPE_W-1:0]       req_tuser,
   // tdata: char_code[7:0], read_row[12:8], read_col[19:13], zero pad[23:20]
   input  wire logic [tccb_pkg::REQ_TDATA_W-1:0]      req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // tdata: cell_char[7:0], cursor_line[12:8], cursor_pos[19:13], scrolled[20], pad[23:21]
   output logic      [tccb_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);

   import tccb_pkg::*;

   localparam int unsigned RW = $clog2(ROWS);
   localparam int unsigned CW = $clog2(COLUMNS);
   localparam int unsigned AW = RW + CW;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [CHAR_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [CHAR_W-1:0] ram_rd_data;
   logic              res_valid;
   result_type        res_data;
   logic              out_free;
   logic              rsp_valid_ff;
   result_type        rsp_data_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   tccb_ctrl #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS),
      .RW      (RW),
      .CW      (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_type    (req_tuser),
      .char_code   (req_tdata[7:0]),
      .read_row    (req_tdata[12:8]),
      .read_col    (req_tdata[19:13]),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .res_valid   (res_valid),
      .res_data    (res_data),
      .out_free    (out_free)
   );

   tccb_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (1 << AW)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_valid && out_free) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - $bits(result_type)){1'b0}}, rsp_data_ff};

endmodule

`default_nettype wire

>>> hdl/tccb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tccb_checker #(
   parameter int unsigned ROWS    = 25,
   parameter int unsigned COLUMNS = 80
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // One request is worked on at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in work");

   // The cursor never leaves the screen.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[19:13]) < COLUMNS) && (32'(rsp_tdata[12:8]) < ROWS))
      else $error("cursor outside the screen");

   // A scroll always leaves the cursor at the start of the bottom row.
   a_scroll_home: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[20] |->
         (32'(rsp_tdata[12:8]) == ROWS - 1) && (rsp_tdata[19:13] == 7'd0))
      else $error("scroll with cursor not at bottom row start");

endmodule

bind text_console_cell_buffer_top tccb_checker #(
   .ROWS    (ROWS),
   .COLUMNS (COLUMNS)
) u_tccb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
